>>> hw/rtl/rv32af_pkg.sv
// Package with the beat types and operation codes of the RV32 ALU with flags.
package rv32af_pkg;

   localparam int unsigned XLEN = 32;
   localparam int unsigned FUNC_W = 5;
   localparam int unsigned SHAMT_W = 5;

   localparam logic [FUNC_W-1:0] FUNC_ADD  = 5'd0;
   localparam logic [FUNC_W-1:0] FUNC_SUB  = 5'd1;
   localparam logic [FUNC_W-1:0] FUNC_AND  = 5'd2;
   localparam logic [FUNC_W-1:0] FUNC_OR   = 5'd3;
   localparam logic [FUNC_W-1:0] FUNC_XOR  = 5'd4;
   localparam logic [FUNC_W-1:0] FUNC_SLL  = 5'd5;
   localparam logic [FUNC_W-1:0] FUNC_SRL  = 5'd6;
   localparam logic [FUNC_W-1:0] FUNC_SRA  = 5'd7;
   localparam logic [FUNC_W-1:0] FUNC_SLT  = 5'd8;
   localparam logic [FUNC_W-1:0] FUNC_SLTU = 5'd9;
   localparam logic [FUNC_W-1:0] FUNC_PASSA = 5'd10;
   localparam logic [FUNC_W-1:0] FUNC_PASSB = 5'd11;

   typedef struct packed {
      logic [XLEN-1:0]   a;
      logic [XLEN-1:0]   b;
      logic [FUNC_W-1:0] func;
   } req_type;

   typedef struct packed {
      logic [XLEN-1:0] result;
      logic            zero;
      logic            eq;
      logic            less_signed;
      logic            less_unsigned;
      logic            negative;
      logic            carry;
      logic            overflow;
   } rsp_type;

endpackage

>>> hw/rtl/rv32_alu_with_flags_top.sv
// Top level of the RV32 ALU with flags: input register, ALU datapath and result register.
// A beat passes from the input register through the ALU into the result register.
// One beat per cycle while rsp_ready is high; a single ALU pass lies between the registers.
// While a result waits, one more beat enters the input register, then the input stalls.
// Reset is synchronous and active high; it clears both valid bits, payload is not reset.
module rv32_alu_with_flags_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rv32af_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rv32af_pkg::rsp_type rsp_data
);

   logic                s1_valid_ff;
   logic                s1_valid_in;
   rv32af_pkg::req_type s1_data_ff;
   rv32af_pkg::req_type s1_data_in;
   logic                s2_valid_ff;
   logic                s2_valid_in;
   rv32af_pkg::rsp_type s2_data_ff;
   rv32af_pkg::rsp_type s2_data_in;
   rv32af_pkg::rsp_type alu_rsp;
   logic                s2_open;
   logic                s1_move;
   logic                req_take;

   rv32af_alu u_alu (
      .req (s1_data_ff),
      .rsp (alu_rsp)
   );

   always_comb begin
      s2_open     = !s2_valid_ff || rsp_ready;
      s1_move     = s1_valid_ff && s2_open;
      req_ready   = !s1_valid_ff || s2_open;
      req_take    = req_valid && req_ready;
      s1_valid_in = req_take || (s1_valid_ff && !s1_move);
      s1_data_in  = req_take ? req_data : s1_data_ff;
      s2_valid_in = s1_move || (s2_valid_ff && !rsp_ready);
      s2_data_in  = s1_move ? alu_rsp : s2_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_data_ff <= s1_data_in;
      s2_data_ff <= s2_data_in;
   end

   assign rsp_valid = s2_valid_ff;
   assign rsp_data  = s2_data_ff;

   a_reset_empties : assert property (@(posedge clock)
      !reset && $past(reset) |-> !s1_valid_ff && !rsp_valid)
      else $error("Pipeline not empty after reset.");

   a_take_loads : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("Accepted beat did not enter the input register.");

   a_s1_holds : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_open |=> s1_valid_ff && $stable(s1_data_ff))
      else $error("Input register changed while the result register was blocked.");

   a_zero_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.zero == (rsp_data.result == '0))
      else $error("Zero flag does not match the result.");

   a_eq_not_lt : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.eq |-> !rsp_data.less_signed && !rsp_data.less_unsigned)
      else $error("Equal operands reported as less than.");

endmodule

>>> hw/rtl/rv32af_alu.sv
// Combinational ALU datapath: shared adder, logic ops, shifter, result select and flags.
module rv32af_alu (
   input  rv32af_pkg::req_type req,
   output rv32af_pkg::rsp_type rsp
);

   logic                               is_sub;
   logic                               is_arith;
   logic [rv32af_pkg::XLEN-1:0]        bop;
   logic [rv32af_pkg::XLEN:0]          wide;
   logic [rv32af_pkg::XLEN-1:0]        sum;
   logic                               cy;
   logic                               ov;
   logic                               lts;
   logic                               ltu;
   logic [rv32af_pkg::SHAMT_W-1:0]     shamt;
   logic [rv32af_pkg::XLEN-1:0]        res;

   always_comb begin
      is_sub = (req.func == rv32af_pkg::FUNC_SUB) || (req.func == rv32af_pkg::FUNC_SLT) ||
               (req.func == rv32af_pkg::FUNC_SLTU);
      is_arith = is_sub || (req.func == rv32af_pkg::FUNC_ADD);
      bop = is_sub ? ~req.b : req.b;
      wide = {1'b0, req.a} + {1'b0, bop} + {{rv32af_pkg::XLEN{1'b0}}, is_sub};
      sum = wide[rv32af_pkg::XLEN-1:0];
      cy = wide[rv32af_pkg::XLEN];
      ov = (req.a[rv32af_pkg::XLEN-1] == bop[rv32af_pkg::XLEN-1]) &&
           (sum[rv32af_pkg::XLEN-1] != req.a[rv32af_pkg::XLEN-1]);
      lts = is_sub & (sum[rv32af_pkg::XLEN-1] ^ ov);
      ltu = is_sub & ~cy;
      shamt = req.b[rv32af_pkg::SHAMT_W-1:0];

      unique case (req.func)
         rv32af_pkg::FUNC_ADD,
         rv32af_pkg::FUNC_SUB:   res = sum;
         rv32af_pkg::FUNC_AND:   res = req.a & req.b;
         rv32af_pkg::FUNC_OR:    res = req.a | req.b;
         rv32af_pkg::FUNC_XOR:   res = req.a ^ req.b;
         rv32af_pkg::FUNC_SLL:   res = req.a << shamt;
         rv32af_pkg::FUNC_SRL:   res = req.a >> shamt;
         rv32af_pkg::FUNC_SRA:   res = rv32af_pkg::XLEN'($signed(req.a) >>> shamt);
         rv32af_pkg::FUNC_SLT:   res = {{(rv32af_pkg::XLEN-1){1'b0}}, lts};
         rv32af_pkg::FUNC_SLTU:  res = {{(rv32af_pkg::XLEN-1){1'b0}}, ltu};
         rv32af_pkg::FUNC_PASSA: res = req.a;
         rv32af_pkg::FUNC_PASSB: res = req.b;
         default:                res = '0;
      endcase

      rsp.result        = res;
      rsp.zero          = (res == '0);
      rsp.eq            = is_sub && (sum == '0);
      rsp.less_signed   = lts;
      rsp.less_unsigned = ltu;
      rsp.negative      = res[rv32af_pkg::XLEN-1];
      rsp.carry         = is_arith & cy;
      rsp.overflow      = is_arith & ov;
   end

endmodule
